@@ sv/gwr_pkg.sv @@
package gwr_pkg;

	localparam int GRID_W  = 8;
	localparam int GRID_H  = 8;
	localparam int CELLS   = GRID_W * GRID_H;
	localparam int IDX_W   = $clog2(CELLS);
	localparam int DIST_W  = $clog2(CELLS);
	localparam int LAYER_W = DIST_W + 1;
	localparam int COORD_W = 3;
	localparam int COLOR_W = 3;
	localparam int SEG_W   = 6;
	localparam int STK_W   = 2 * COORD_W + SEG_W;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_MOVE  = 1'b1;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [COLOR_W-1:0] color_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_MOVE,
		OP_FAIL
	} op_t;

	typedef enum logic [1:0] {
		DIR_E,
		DIR_S,
		DIR_W,
		DIR_N
	} dir_t;

	typedef struct packed {
		op_t    op;
		idx_t   src_idx;
		idx_t   dst_idx;
		coord_t src_x;
		coord_t src_y;
		coord_t dst_x;
		coord_t dst_y;
		color_t color;
	} item_t;

	typedef struct packed {
		logic               start;
		logic               step;
		logic               occ_we;
		idx_t               occ_idx;
		logic               occ_val;
		idx_t               src_idx;
		logic [DIST_W-1:0]  want;
		logic [LAYER_W-1:0] layer;
	} grid_cmd_t;

	typedef struct packed {
		logic [CELLS-1:0] reached;
		logic [CELLS-1:0] occ;
		logic [CELLS-1:0] match;
		logic             grew;
	} grid_stat_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_FLOOD,
		BK_TRACE,
		BK_COLOR_WR,
		BK_VACATE,
		BK_EMIT_SRC,
		BK_EMIT_WAIT,
		BK_EMIT,
		BK_FAIL
	} bk_state_t;

endpackage

@@ sv/gwr_ram.sv @@
module gwr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/gwr_front.sv @@
module gwr_front import gwr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  logic   func,
	input  coord_t src_x,
	input  coord_t src_y,
	input  color_t color,
	input  coord_t dest_x,
	input  coord_t dest_y,
	input  logic   pop,
	output item_t  head,
	output logic   head_valid
);

	item_t      slot_q [2];
	logic [1:0] count_q;
	logic       rd_q;
	logic       wr_q;
	logic       src_in;
	logic       dst_in;
	logic       accept;
	logic       push;
	item_t      item;

	assign src_in = ({1'b0, src_x} < (COORD_W + 1)'(GRID_W)) &&
	                ({1'b0, src_y} < (COORD_W + 1)'(GRID_H));
	assign dst_in = ({1'b0, dest_x} < (COORD_W + 1)'(GRID_W)) &&
	                ({1'b0, dest_y} < (COORD_W + 1)'(GRID_H));

	always_comb begin
		item.src_idx = IDX_W'(int'(src_y) * GRID_W + int'(src_x));
		item.dst_idx = IDX_W'(int'(dest_y) * GRID_W + int'(dest_x));
		item.src_x   = src_x;
		item.src_y   = src_y;
		item.dst_x   = dest_x;
		item.dst_y   = dest_y;
		item.color   = color;
		unique case (func)
			FUNC_WRITE: item.op = OP_WRITE;
			FUNC_MOVE:  item.op = (src_in && dst_in) ? OP_MOVE : OP_FAIL;
			default:    item.op = OP_FAIL;
		endcase
	end

	assign in_stall   = (count_q == 2'd2);
	assign accept     = in_valid && !in_stall;
	// drop off-grid writes
	assign push       = accept && !(func == FUNC_WRITE && !src_in);
	assign head       = slot_q[rd_q];
	assign head_valid = (count_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			rd_q    <= 1'b0;
			wr_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ sv/gwr_grid.sv @@
module gwr_grid import gwr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  grid_cmd_t  cmd,
	output grid_stat_t stat
);

	logic [CELLS-1:0]  reached_q;
	logic [CELLS-1:0]  occ_q;
	logic [CELLS-1:0]  fresh;
	logic [CELLS-1:0]  match;
	logic [DIST_W-1:0] dist_q [CELLS];

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		localparam int CX = i % GRID_W;
		localparam int CY = i / GRID_W;
		logic e, s, w, n;

		if (CX < GRID_W - 1) begin : g_e
			assign e = reached_q[i+1];
		end else begin : g_ne
			assign e = 1'b0;
		end
		if (CY < GRID_H - 1) begin : g_s
			assign s = reached_q[i+GRID_W];
		end else begin : g_ns
			assign s = 1'b0;
		end
		if (CX > 0) begin : g_w
			assign w = reached_q[i-1];
		end else begin : g_nw
			assign w = 1'b0;
		end
		if (CY > 0) begin : g_n
			assign n = reached_q[i-GRID_W];
		end else begin : g_nn
			assign n = 1'b0;
		end

		assign fresh[i] = !reached_q[i] && !occ_q[i] && (e || s || w || n);
		assign match[i] = reached_q[i] && (dist_q[i] == cmd.want);

		always_ff @(posedge clk) begin
			if (cmd.start && cmd.src_idx == IDX_W'(i)) begin
				dist_q[i] <= '0;
			end else if (cmd.step && fresh[i]) begin
				dist_q[i] <= DIST_W'(cmd.layer);
			end
		end
	end

	assign stat = '{reached: reached_q, occ: occ_q, match: match, grew: |fresh};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q <= '0;
			occ_q     <= '0;
		end else begin
			if (cmd.start) begin
				reached_q <= CELLS'(1) << cmd.src_idx;
			end else if (cmd.step) begin
				reached_q <= reached_q | fresh;
			end
			if (cmd.occ_we) begin
				occ_q[cmd.occ_idx] <= cmd.occ_val;
			end
		end
	end

endmodule

@@ sv/gwr_back.sv @@
module gwr_back import gwr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            head,
	input  logic             head_valid,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             found,
	output coord_t           point_x,
	output coord_t           point_y,
	output logic [SEG_W-1:0] segment_len,
	output logic             last
);

	bk_state_t          state_q, state_d;
	grid_cmd_t          cmd;
	grid_stat_t         stat;
	logic [LAYER_W-1:0] layer_q;
	logic [DIST_W-1:0]  want_q;
	logic [DIST_W-1:0]  rem_q;
	coord_t             cur_x_q, cur_y_q, pend_x_q, pend_y_q;
	idx_t               cur_idx_q;
	logic [SEG_W-1:0]   run_q;
	idx_t               k_q;
	idx_t               ptr_q;
	logic               axis_q;
	logic               first_q;

	logic               out_free;
	logic               ld;
	logic               ld_found, ld_last;
	coord_t             ld_x, ld_y;
	logic [SEG_W-1:0]   ld_seg;

	logic               stk_we;
	logic [STK_W-1:0]   stk_rdata;
	logic               cram_we;
	idx_t               cram_waddr;
	color_t             cram_wdata, cram_rdata;

	logic               move_ok;
	logic               dst_hit;
	idx_t               e_idx, s_idx, w_idx, n_idx, nb_idx;
	coord_t             nb_x, nb_y;
	dir_t               dir;
	logic               axis;
	logic               corner;

	assign out_free = !out_valid || !out_stall;
	assign move_ok  = stat.occ[head.src_idx] && !stat.occ[head.dst_idx];
	assign dst_hit  = stat.reached[head.dst_idx];

	assign e_idx = cur_idx_q + idx_t'(1);
	assign s_idx = cur_idx_q + idx_t'(GRID_W);
	assign w_idx = cur_idx_q - idx_t'(1);
	assign n_idx = cur_idx_q - idx_t'(GRID_W);

	always_comb begin
		if ({1'b0, cur_x_q} < (COORD_W + 1)'(GRID_W - 1) && stat.match[e_idx]) begin
			dir = DIR_E;
		end else if ({1'b0, cur_y_q} < (COORD_W + 1)'(GRID_H - 1) &&
		             stat.match[s_idx]) begin
			dir = DIR_S;
		end else if (cur_x_q != '0 && stat.match[w_idx]) begin
			dir = DIR_W;
		end else begin
			dir = DIR_N;
		end
		unique case (dir)
			DIR_E: begin
				nb_idx = e_idx;
				nb_x   = cur_x_q + coord_t'(1);
				nb_y   = cur_y_q;
			end
			DIR_S: begin
				nb_idx = s_idx;
				nb_x   = cur_x_q;
				nb_y   = cur_y_q + coord_t'(1);
			end
			DIR_W: begin
				nb_idx = w_idx;
				nb_x   = cur_x_q - coord_t'(1);
				nb_y   = cur_y_q;
			end
			default: begin
				nb_idx = n_idx;
				nb_x   = cur_x_q;
				nb_y   = cur_y_q - coord_t'(1);
			end
		endcase
	end

	assign axis   = (dir == DIR_S) || (dir == DIR_N);
	assign corner = !first_q && (axis != axis_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (head_valid) begin
					unique case (head.op)
						OP_WRITE: state_d = BK_IDLE;
						OP_MOVE:  state_d = move_ok ? BK_FLOOD : BK_FAIL;
						default:  state_d = BK_FAIL;
					endcase
				end
			end
			BK_FLOOD: begin
				if (dst_hit) begin
					state_d = BK_TRACE;
				end else if (!stat.grew) begin
					state_d = BK_FAIL;
				end
			end
			BK_TRACE: begin
				if (rem_q == '0) begin
					state_d = BK_COLOR_WR;
				end
			end
			BK_COLOR_WR: state_d = BK_VACATE;
			BK_VACATE:   state_d = BK_EMIT_SRC;
			BK_EMIT_SRC: begin
				if (out_free) begin
					state_d = BK_EMIT_WAIT;
				end
			end
			BK_EMIT_WAIT: state_d = BK_EMIT;
			BK_EMIT: begin
				if (out_free) begin
					state_d = (ptr_q == '0) ? BK_IDLE : BK_EMIT_WAIT;
				end
			end
			BK_FAIL: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		cmd        = '0;
		cmd.src_idx = head.src_idx;
		cmd.want   = want_q;
		cmd.layer  = layer_q;
		stk_we     = 1'b0;
		cram_we    = 1'b0;
		cram_waddr = head.src_idx;
		cram_wdata = head.color;
		ld         = 1'b0;
		ld_found   = 1'b0;
		ld_x       = '0;
		ld_y       = '0;
		ld_seg     = '0;
		ld_last    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (head_valid && head.op == OP_WRITE) begin
					cram_we     = 1'b1;
					cmd.occ_we  = 1'b1;
					cmd.occ_idx = head.src_idx;
					cmd.occ_val = |head.color;
					pop         = 1'b1;
				end
				if (head_valid && head.op == OP_MOVE && move_ok) begin
					cmd.start = 1'b1;
				end
			end
			BK_FLOOD: begin
				cmd.step = !dst_hit;
			end
			BK_TRACE: begin
				stk_we = (rem_q == '0) || corner;
			end
			BK_COLOR_WR: begin
				cram_we     = 1'b1;
				cram_waddr  = head.dst_idx;
				cram_wdata  = cram_rdata;
				cmd.occ_we  = 1'b1;
				cmd.occ_idx = head.dst_idx;
				cmd.occ_val = 1'b1;
			end
			BK_VACATE: begin
				cmd.occ_we  = 1'b1;
				cmd.occ_idx = head.src_idx;
				cmd.occ_val = 1'b0;
			end
			BK_EMIT_SRC: begin
				ld       = out_free;
				ld_found = 1'b1;
				ld_x     = head.src_x;
				ld_y     = head.src_y;
			end
			BK_EMIT_WAIT: begin
			end
			BK_EMIT: begin
				ld       = out_free;
				ld_found = 1'b1;
				ld_x     = stk_rdata[STK_W-1 -: COORD_W];
				ld_y     = stk_rdata[SEG_W +: COORD_W];
				ld_seg   = stk_rdata[SEG_W-1:0];
				ld_last  = (ptr_q == '0);
				pop      = out_free && (ptr_q == '0);
			end
			BK_FAIL: begin
				ld      = out_free;
				ld_last = 1'b1;
				pop     = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			found       <= ld_found;
			point_x     <= ld_x;
			point_y     <= ld_y;
			segment_len <= ld_seg;
			last        <= ld_last;
		end
		unique case (state_q)
			BK_IDLE: begin
				layer_q <= LAYER_W'(1);
			end
			BK_FLOOD: begin
				if (dst_hit) begin
					want_q    <= DIST_W'(layer_q - LAYER_W'(2));
					rem_q     <= DIST_W'(layer_q - LAYER_W'(1));
					cur_x_q   <= head.dst_x;
					cur_y_q   <= head.dst_y;
					cur_idx_q <= head.dst_idx;
					pend_x_q  <= head.dst_x;
					pend_y_q  <= head.dst_y;
					run_q     <= '0;
					k_q       <= '0;
					first_q   <= 1'b1;
				end else begin
					layer_q <= layer_q + LAYER_W'(1);
				end
			end
			BK_TRACE: begin
				if (rem_q == '0) begin
					k_q <= k_q + idx_t'(1);
				end else begin
					if (corner) begin
						k_q      <= k_q + idx_t'(1);
						pend_x_q <= cur_x_q;
						pend_y_q <= cur_y_q;
						run_q    <= SEG_W'(1);
					end else begin
						run_q <= run_q + SEG_W'(1);
					end
					cur_x_q   <= nb_x;
					cur_y_q   <= nb_y;
					cur_idx_q <= nb_idx;
					want_q    <= want_q - DIST_W'(1);
					rem_q     <= rem_q - DIST_W'(1);
					axis_q    <= axis;
					first_q   <= 1'b0;
				end
			end
			BK_EMIT_SRC: begin
				if (out_free) begin
					ptr_q <= k_q - idx_t'(1);
				end
			end
			BK_EMIT: begin
				if (out_free && ptr_q != '0) begin
					ptr_q <= ptr_q - idx_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	gwr_grid u_grid (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	gwr_ram #(.WIDTH(STK_W), .DEPTH(CELLS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (k_q),
		.wdata ({pend_x_q, pend_y_q, run_q}),
		.raddr (ptr_q),
		.rdata (stk_rdata)
	);

	gwr_ram #(.WIDTH(COLOR_W), .DEPTH(CELLS)) u_colors (
		.clk   (clk),
		.we    (cram_we),
		.waddr (cram_waddr),
		.wdata (cram_wdata),
		.raddr (head.src_idx),
		.rdata (cram_rdata)
	);

endmodule

@@ sv/grid_wavefront_path_router_top.sv @@
// Write item: retired in its first cycle at the queue head, no result.
// Move item: flood layers grow from the source until the destination is reached, then the path
// is traced back and stored, and the source and each waypoint are emitted as results.
// Throughput is one item at a time in the back end; a 2-entry queue takes items meanwhile.
// Reset (arst_n low, asynchronous) empties the grid and the queue; no clearing pass.
module grid_wavefront_path_router_top import gwr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             func,
	input  coord_t           src_x,
	input  coord_t           src_y,
	input  color_t           color,
	input  coord_t           dest_x,
	input  coord_t           dest_y,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             found,
	output coord_t           point_x,
	output coord_t           point_y,
	output logic [SEG_W-1:0] segment_len,
	output logic             last
);

	item_t head;
	logic  head_valid;
	logic  pop;

	gwr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.src_x      (src_x),
		.src_y      (src_y),
		.color      (color),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	gwr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.point_x     (point_x),
		.point_y     (point_y),
		.segment_len (segment_len),
		.last        (last)
	);

endmodule

@@ sv/gwr_checker.sv @@
module gwr_checker import gwr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic             found,
	input coord_t           point_x,
	input coord_t           point_y,
	input logic [SEG_W-1:0] segment_len,
	input logic             last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y) &&
		$stable(segment_len) && $stable(last) && $stable(found))
		else $error("stalled item changed");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> last && point_x == '0 && point_y == '0 &&
		segment_len == '0)
		else $error("not-found item malformed");

	a_dest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found && last |-> segment_len != '0)
		else $error("destination with empty segment");

endmodule

bind grid_wavefront_path_router_top gwr_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.found       (found),
	.point_x     (point_x),
	.point_y     (point_y),
	.segment_len (segment_len),
	.last        (last)
);

@@ sim/grid_wavefront_path_router_top_test.sv @@
module grid_wavefront_path_router_top_test;
	import gwr_pkg::*;

	typedef struct {
		logic             found;
		coord_t           px;
		coord_t           py;
		logic [SEG_W-1:0] seg;
		logic             last;
	} waypoint_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             func;
	coord_t           src_x;
	coord_t           src_y;
	color_t           color;
	coord_t           dest_x;
	coord_t           dest_y;
	logic             out_valid;
	logic             out_stall;
	logic             found;
	coord_t           point_x;
	coord_t           point_y;
	logic [SEG_W-1:0] segment_len;
	logic             last;

	color_t    board[CELLS];
	waypoint_t route_q[$];
	int        errors;
	int        moves_sent;
	int        hold_cycles;
	bit        rx_random;
	int        gap_max;

	grid_wavefront_path_router_top i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.func(func), .src_x(src_x), .src_y(src_y), .color(color),
		.dest_x(dest_x), .dest_y(dest_y), .out_valid(out_valid),
		.out_stall(out_stall), .found(found), .point_x(point_x),
		.point_y(point_y), .segment_len(segment_len), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (gap_max == 0 || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, gap_max);
	endfunction

	function automatic void push_miss();
		waypoint_t w;
		w.found = 1'b0;
		w.px = '0;
		w.py = '0;
		w.seg = '0;
		w.last = 1'b1;
		route_q.push_back(w);
	endfunction

	function automatic void route_move(int sx, int sy, int tx, int ty);
		bit   seen[CELLS];
		int   wave_d[CELLS];
		int   fifo[CELLS];
		int   hd, tl, c, nx, ny, ni, k, n, i, len, cx, cy, want, s, d;
		int   px[CELLS], py[CELLS], wx[CELLS], wy[CELLS];
		int   ddx[4] = '{1, 0, -1, 0};
		int   ddy[4] = '{0, 1, 0, -1};
		waypoint_t w;
		s = sy * GRID_W + sx;
		d = ty * GRID_W + tx;
		if (board[s] == 0 || board[d] != 0) begin
			push_miss();
			return;
		end
		foreach (seen[j]) begin
			seen[j] = 1'b0;
			wave_d[j] = 0;
		end
		hd = 0;
		tl = 0;
		seen[s] = 1'b1;
		fifo[tl++] = s;
		while (hd < tl) begin
			c = fifo[hd++];
			for (k = 0; k < 4; k++) begin
				nx = c % GRID_W + ddx[k];
				ny = c / GRID_W + ddy[k];
				if (nx < 0 || ny < 0 || nx >= GRID_W || ny >= GRID_H)
					continue;
				ni = ny * GRID_W + nx;
				if (seen[ni] || board[ni] != 0)
					continue;
				seen[ni] = 1'b1;
				wave_d[ni] = wave_d[c] + 1;
				fifo[tl++] = ni;
			end
		end
		if (!seen[d]) begin
			push_miss();
			return;
		end
		len = wave_d[d] + 1;
		cx = tx;
		cy = ty;
		px[len-1] = cx;
		py[len-1] = cy;
		for (i = len - 2; i >= 0; i--) begin
			want = wave_d[cy * GRID_W + cx] - 1;
			for (k = 0; k < 4; k++) begin
				nx = cx + ddx[k];
				ny = cy + ddy[k];
				if (nx < 0 || ny < 0 || nx >= GRID_W || ny >= GRID_H)
					continue;
				ni = ny * GRID_W + nx;
				if (seen[ni] && wave_d[ni] == want) begin
					cx = nx;
					cy = ny;
					break;
				end
			end
			px[i] = cx;
			py[i] = cy;
		end
		n = 0;
		wx[0] = px[0];
		wy[0] = py[0];
		n = 1;
		for (i = 1; i + 1 < len; i++) begin
			if ((wx[n-1] == px[i] && px[i+1] == px[i]) ||
			    (wy[n-1] == py[i] && py[i+1] == py[i]))
				continue;
			wx[n] = px[i];
			wy[n] = py[i];
			n++;
		end
		wx[n] = px[len-1];
		wy[n] = py[len-1];
		n++;
		for (i = 0; i < n; i++) begin
			w.found = 1'b1;
			w.px = coord_t'(wx[i]);
			w.py = coord_t'(wy[i]);
			w.seg = SEG_W'((i == 0) ? 0 :
				((wx[i] > wx[i-1] ? wx[i] - wx[i-1] : wx[i-1] - wx[i])
				+ (wy[i] > wy[i-1] ? wy[i] - wy[i-1] : wy[i-1] - wy[i])));
			w.last = (i == n - 1);
			route_q.push_back(w);
		end
		board[d] = board[s];
		board[s] = '0;
	endfunction

	task automatic send_item(logic f, int sx, int sy, int col, int tx, int ty);
		int gap;
		sx = sx & 7;
		sy = sy & 7;
		col = col & 7;
		tx = tx & 7;
		ty = ty & 7;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		src_x <= coord_t'(sx);
		src_y <= coord_t'(sy);
		color <= color_t'(col);
		dest_x <= coord_t'(tx);
		dest_y <= coord_t'(ty);
		do
			@(posedge clk);
		while (in_stall);
		if (f == FUNC_WRITE)
			board[sy * GRID_W + sx] = color_t'(col);
		else begin
			route_move(sx, sy, tx, ty);
			moves_sent++;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (route_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic clear_board();
		for (int y = 0; y < GRID_H; y++)
			for (int x = 0; x < GRID_W; x++)
				if (board[y * GRID_W + x] != 0)
					send_item(FUNC_WRITE, x, y, 0, $urandom, $urandom);
	endtask

	task automatic test_directed();
		send_item(FUNC_MOVE, 0, 0, 7, 7, 7);
		send_item(FUNC_WRITE, 0, 0, 7, 7, 7);
		send_item(FUNC_MOVE, 0, 0, 0, 0, 0);
		send_item(FUNC_MOVE, 0, 0, 0, 7, 7);
		send_item(FUNC_WRITE, 7, 0, 5, 0, 0);
		send_item(FUNC_MOVE, 7, 7, 0, 7, 0);
		send_item(FUNC_WRITE, 3, 3, 1, 0, 0);
		send_item(FUNC_WRITE, 3, 4, 2, 0, 0);
		send_item(FUNC_MOVE, 7, 7, 0, 3, 4);
		send_item(FUNC_MOVE, 7, 7, 0, 4, 3);
		send_item(FUNC_WRITE, 0, 1, 3, 0, 0);
		send_item(FUNC_WRITE, 1, 0, 3, 0, 0);
		send_item(FUNC_WRITE, 1, 1, 4, 0, 0);
		send_item(FUNC_MOVE, 0, 0, 0, 5, 5);
		send_item(FUNC_MOVE, 1, 1, 0, 0, 0);
		send_item(FUNC_MOVE, 1, 1, 0, 6, 7);
		for (int y = 0; y < GRID_H - 1; y++)
			send_item(FUNC_WRITE, (y % 2) ? 0 : 7, y, 6, 0, 0);
		drain();
		clear_board();
	endtask

	task automatic test_serpentine();
		for (int y = 1; y < GRID_H; y += 2)
			for (int x = 0; x < GRID_W - 1; x++)
				send_item(FUNC_WRITE, (y % 4 == 1) ? x + 1 : x, y, 2, 0, 0);
		send_item(FUNC_WRITE, 0, 0, 3, 0, 0);
		send_item(FUNC_MOVE, 0, 0, 0, 7, 7);
		drain();
		clear_board();
		drain();
	endtask

	task automatic test_random(int count);
		int r, x, y, tx, ty;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				send_item(FUNC_WRITE, $urandom, $urandom,
					($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7),
					$urandom, $urandom);
			else if (r < 85) begin
				do begin
					x = $urandom_range(0, 7);
					y = $urandom_range(0, 7);
				end while (board[y * GRID_W + x] == 0 && $urandom_range(0, 9) != 0);
				do begin
					tx = $urandom_range(0, 7);
					ty = $urandom_range(0, 7);
				end while (board[ty * GRID_W + tx] != 0 && $urandom_range(0, 9) != 0);
				send_item(FUNC_MOVE, x, y, $urandom, tx, ty);
			end else
				send_item(FUNC_MOVE, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 600;
		send_item(FUNC_WRITE, 2, 2, 4, 0, 0);
		for (int i = 0; i < 6; i++)
			send_item(FUNC_MOVE, 2 + (i % 2) * 3, 2, 0, 5 - (i % 2) * 3, 2);
		drain();
		wait (hold_cycles == 0);
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
		out_stall <= (hold_cycles > 1) ? 1'b1 :
			(rx_random && $urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
	end

	always @(posedge clk) begin
		waypoint_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (route_q.size() == 0) begin
				$error("unexpected result found=%0d x=%0d y=%0d", found, point_x, point_y);
				errors++;
			end else begin
				w = route_q.pop_front();
				if (found !== w.found) begin
					$error("found exp %0d got %0d", w.found, found);
					errors++;
				end
				if (point_x !== w.px) begin
					$error("point_x exp %0d got %0d", w.px, point_x);
					errors++;
				end
				if (point_y !== w.py) begin
					$error("point_y exp %0d got %0d", w.py, point_y);
					errors++;
				end
				if (segment_len !== w.seg) begin
					$error("segment_len exp %0d got %0d", w.seg, segment_len);
					errors++;
				end
				if (last !== w.last) begin
					$error("last exp %0d got %0d", w.last, last);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		moves_sent = 0;
		hold_cycles = 0;
		rx_random = 1'b0;
		gap_max = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_WRITE;
		src_x = '0;
		src_y = '0;
		color = '0;
		dest_x = '0;
		dest_y = '0;
		out_stall = 1'b0;
		foreach (board[j])
			board[j] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		gap_max = 20;
		rx_random = 1'b1;
		test_serpentine();
		test_backpressure();
		test_random(170);
		gap_max = 0;
		rx_random = 1'b0;
		test_random(60);
		gap_max = 30;
		rx_random = 1'b1;
		test_random(80);
		drain();
		repeat (400) @(posedge clk);
		if (errors == 0 && route_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
